FILE: hw/rtl/tesq_pkg.sv
// Package for the timed event slot queue: sizes, command and state codes,
// slot and chain control types. Used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tesq_pkg;

    // Number of event slots and field widths
    localparam int SLOTS  = 16;
    localparam int IdW    = 4;
    localparam int CmdW   = 2;
    localparam int TimeW  = 64;
    localparam int DelayW = 32;
    localparam int CntW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [CmdW-1:0] {
        CMD_INSERT = 2'd0,
        CMD_NEXT   = 2'd1,
        CMD_FIRE   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_ROTATE,
        OP_INSERT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_SCAN,
        ST_DONE
    } state_t;

    // One pending event as held by a cell
    typedef struct packed {
        logic             valid;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] due;
    } slot_t;

    // Control broadcast from the sequencer to the cell chain
    typedef struct packed {
        cell_op_t         op;
        logic [IdW-1:0]   id;
        logic [TimeW-1:0] due;
        logic             drop;
    } chain_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tesq_cell.sv
// One cell of the event chain: holds one slot, shifts toward the tail on a
// new insert and toward the head while the chain rotates. Uses tesq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tesq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  tesq_pkg::chain_ctl_t ctl,
    input  logic                hit,
    input  logic                carry_in,
    input  tesq_pkg::slot_t     left_in,
    input  tesq_pkg::slot_t     right_in,
    output tesq_pkg::slot_t     slot,
    output logic                carry_out,
    output logic                match
);
    import tesq_pkg::*;

    logic             valid_reg, valid_next;
    logic [IdW-1:0]   id_reg, id_next;
    logic [TimeW-1:0] due_reg, due_next;

    // Flag this cell when it holds the id being inserted
    assign match     = valid_reg && (id_reg == ctl.id);
    // Pass the shift on while every cell so far is occupied
    assign carry_out = carry_in && valid_reg;

    assign slot.valid = valid_reg;
    assign slot.id    = id_reg;
    assign slot.due   = due_reg;

    // Select the next contents of the cell
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        due_next   = due_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            OP_ROTATE:
            begin
                valid_next = right_in.valid;
                id_next    = right_in.id;
                due_next   = right_in.due;
            end
            OP_INSERT:
            begin
                if (hit)
                begin
                    if (match)
                    begin
                        due_next = ctl.due;
                    end
                end
                else if (carry_in)
                begin
                    valid_next = left_in.valid;
                    id_next    = left_in.id;
                    due_next   = left_in.due;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the occupancy bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the slot payload
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        due_reg <= due_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tesq_ctrl.sv
// Sequencer of the event queue: command handshake, scan counter, soonest-time
// and fired-event tracking, result register and the empty marker register.
// Uses tesq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tesq_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  logic [tesq_pkg::CmdW-1:0]       cmd,
    input  logic [tesq_pkg::IdW-1:0]        event_id,
    input  logic [tesq_pkg::TimeW-1:0]      now,
    input  logic signed [tesq_pkg::DelayW-1:0] delay,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tesq_pkg::TimeW-1:0]      cfg_data,
    input  tesq_pkg::slot_t                 head,
    input  logic                            hit,
    output tesq_pkg::chain_ctl_t            ctl,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [tesq_pkg::CmdW-1:0]       kind,
    output logic [tesq_pkg::IdW-1:0]        fired_id,
    output logic                            fired_valid,
    output logic [tesq_pkg::TimeW-1:0]      next_time,
    output logic                            readd_error,
    output logic                            last
);
    import tesq_pkg::*;

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic [IdW-1:0]            id_reg, id_next;
    logic [TimeW-1:0]          now_reg, now_next;
    logic signed [DelayW-1:0]  delay_reg, delay_next;
    logic [CntW-1:0]           cnt_reg, cnt_next;
    logic [TimeW-1:0]          best_reg, best_next;
    logic [IdW-1:0]            held_id_reg, held_id_next;
    logic                      held_valid_reg, held_valid_next;
    logic                      err_reg, err_next;
    logic [TimeW-1:0]          marker_reg, marker_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic [CmdW-1:0]           rsp_kind_reg, rsp_kind_next;
    logic [IdW-1:0]            rsp_id_reg, rsp_id_next;
    logic                      rsp_fvalid_reg, rsp_fvalid_next;
    logic [TimeW-1:0]          rsp_time_reg, rsp_time_next;
    logic                      rsp_err_reg, rsp_err_next;
    logic                      rsp_last_reg, rsp_last_next;

    cmd_t                      cmd_in;
    logic                      accept;
    logic                      out_free;
    logic                      is_fire;
    logic                      head_due;
    logic                      head_sooner;
    logic                      fire_stall;
    logic                      last_step;
    logic                      id_in_range;
    logic                      advance;
    logic                      push_mid;
    logic                      push_done;

    assign cmd_in      = cmd_t'(cmd);
    assign accept      = cmd_valid && !cmd_stall;
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign is_fire     = (cmd_reg == CMD_FIRE);
    assign head_due    = head.valid && (head.due <= now_reg);
    assign head_sooner = head.valid && (head.due > now_reg) && (head.due < best_reg);
    // A second due event needs the held one delivered first
    assign fire_stall  = is_fire && head_due && held_valid_reg && !out_free;
    assign last_step   = (cnt_reg == CntW'(SLOTS - 1));
    assign id_in_range = (int'(id_reg) < SLOTS);
    assign cfg_ready   = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_in) inside
                        CMD_INSERT:         state_next = ST_INSERT;
                        CMD_NEXT, CMD_FIRE: state_next = ST_SCAN;
                        default:            state_next = ST_DONE;
                    endcase
                end
            end
            ST_INSERT:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                if (advance && last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (push_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, chain control, result pushes
    always_comb
    begin
        cmd_stall = 1'b1;
        ctl.op    = OP_HOLD;
        ctl.id    = id_reg;
        ctl.due   = now_reg + {{(TimeW - DelayW){delay_reg[DelayW-1]}}, delay_reg};
        ctl.drop  = 1'b0;
        advance   = 1'b0;
        push_mid  = 1'b0;
        push_done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                if (cmd_valid && (cmd_in == CMD_CLEAR))
                begin
                    ctl.op = OP_CLEAR;
                end
            end
            ST_INSERT:
            begin
                if (id_in_range)
                begin
                    ctl.op = OP_INSERT;
                end
            end
            ST_SCAN:
            begin
                if (!fire_stall)
                begin
                    advance  = 1'b1;
                    ctl.op   = OP_ROTATE;
                    ctl.drop = is_fire && head_due;
                end
                push_mid = is_fire && head_due && held_valid_reg && out_free;
            end
            ST_DONE:
            begin
                push_done = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // Working registers of the current command
    always_comb
    begin
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        delay_next      = delay_reg;
        cnt_next        = cnt_reg;
        best_next       = best_reg;
        held_id_next    = held_id_reg;
        held_valid_next = held_valid_reg;
        err_next        = err_reg;
        marker_next     = marker_reg;

        if (cfg_valid && cfg_ready)
        begin
            marker_next = cfg_data;
        end

        if (accept)
        begin
            // Latch the transaction and reset the scan trackers
            cmd_next        = cmd_in;
            id_next         = event_id;
            now_next        = now;
            delay_next      = delay;
            cnt_next        = '0;
            best_next       = marker_reg;
            held_id_next    = '0;
            held_valid_next = 1'b0;
            err_next        = 1'b0;
        end
        else if (state_reg == ST_INSERT)
        begin
            err_next = id_in_range && hit;
        end
        else if (advance)
        begin
            // Step past the head cell
            cnt_next = cnt_reg + CntW'(1);
            if (!is_fire && head_sooner)
            begin
                best_next = head.due;
            end
            if (is_fire && head_due)
            begin
                held_id_next    = head.id;
                held_valid_next = 1'b1;
            end
        end
    end

    // Result register
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_kind_next   = rsp_kind_reg;
        rsp_id_next     = rsp_id_reg;
        rsp_fvalid_next = rsp_fvalid_reg;
        rsp_time_next   = rsp_time_reg;
        rsp_err_next    = rsp_err_reg;
        rsp_last_next   = rsp_last_reg;
        if (push_mid)
        begin
            rsp_valid_next  = 1'b1;
            rsp_kind_next   = CMD_FIRE;
            rsp_id_next     = held_id_reg;
            rsp_fvalid_next = 1'b1;
            rsp_time_next   = '0;
            rsp_err_next    = 1'b0;
            rsp_last_next   = 1'b0;
        end
        else if (push_done)
        begin
            rsp_valid_next  = 1'b1;
            rsp_kind_next   = cmd_reg;
            rsp_id_next     = held_id_reg;
            rsp_fvalid_next = held_valid_reg;
            rsp_time_next   = (cmd_reg == CMD_NEXT) ? best_reg : '0;
            rsp_err_next    = err_reg;
            rsp_last_next   = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            marker_reg     <= '1;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            marker_reg     <= marker_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        now_reg        <= now_next;
        delay_reg      <= delay_next;
        best_reg       <= best_next;
        held_id_reg    <= held_id_next;
        err_reg        <= err_next;
        rsp_kind_reg   <= rsp_kind_next;
        rsp_id_reg     <= rsp_id_next;
        rsp_fvalid_reg <= rsp_fvalid_next;
        rsp_time_reg   <= rsp_time_next;
        rsp_err_reg    <= rsp_err_next;
        rsp_last_reg   <= rsp_last_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign kind        = rsp_kind_reg;
    assign fired_id    = rsp_id_reg;
    assign fired_valid = rsp_fvalid_reg;
    assign next_time   = rsp_time_reg;
    assign readd_error = rsp_err_reg;
    assign last        = rsp_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/timed_event_slot_queue_top.sv
// Top level of the timed event slot queue: the chain of slot cells and the
// sequencer. Depends on tesq_pkg, tesq_cell and tesq_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Timed event queue with one slot per event id, kept as a chain of SLOTS
// cells in insertion order, newest at the head. One command is in work at a
// time. An insert passes through the insert and done states, a clear through
// the done state alone. A next or fire command rotates the whole chain once
// past the comparators on the head cell, one cell per scan step. The final
// result of each command is loaded into the result register from the done
// state, as the sequencer returns to idle. That final load waits while the
// previous result is still stalled. A fire command also holds its scan while
// the result side stalls and a second expired event is waiting. Fired ids
// come out newest-inserted first, the last one flagged by last. The
// empty_marker register resets to all ones and is written through the cfg
// channel, which is always ready.
module timed_event_slot_queue_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [tesq_pkg::CmdW-1:0]          cmd,
    input  logic [tesq_pkg::IdW-1:0]           event_id,
    input  logic [tesq_pkg::TimeW-1:0]         now,
    input  logic signed [tesq_pkg::DelayW-1:0] delay,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tesq_pkg::TimeW-1:0]         cfg_data,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [tesq_pkg::CmdW-1:0]          kind,
    output logic [tesq_pkg::IdW-1:0]           fired_id,
    output logic                               fired_valid,
    output logic [tesq_pkg::TimeW-1:0]         next_time,
    output logic                               readd_error,
    output logic                               last
);
    import tesq_pkg::*;

    chain_ctl_t        ctl;
    slot_t             cell_q [SLOTS];
    logic              carry [SLOTS+1];
    logic [SLOTS-1:0]  match_vec;
    logic              hit;
    slot_t             new_slot;
    slot_t             tail_in;

    // Entry that enters the head on a new insert
    assign new_slot.valid = 1'b1;
    assign new_slot.id    = ctl.id;
    assign new_slot.due   = ctl.due;

    // Head wraps to the tail on rotation, dropped if it fired
    assign tail_in.valid = cell_q[0].valid && !ctl.drop;
    assign tail_in.id    = cell_q[0].id;
    assign tail_in.due   = cell_q[0].due;

    assign carry[0] = 1'b1;
    assign hit      = |match_vec;

    // Build the chain of slot cells
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        slot_t left_in;
        slot_t right_in;

        if (i == 0)
        begin : g_head
            assign left_in = new_slot;
        end
        else
        begin : g_body
            assign left_in = cell_q[i-1];
        end

        if (i == SLOTS - 1)
        begin : g_tail
            assign right_in = tail_in;
        end
        else
        begin : g_mid
            assign right_in = cell_q[i+1];
        end

        tesq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .hit       (hit),
            .carry_in  (carry[i]),
            .left_in   (left_in),
            .right_in  (right_in),
            .slot      (cell_q[i]),
            .carry_out (carry[i+1]),
            .match     (match_vec[i])
        );
    end

    tesq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .event_id    (event_id),
        .now         (now),
        .delay       (delay),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .head        (cell_q[0]),
        .hit         (hit),
        .ctl         (ctl),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .kind        (kind),
        .fired_id    (fired_id),
        .fired_valid (fired_valid),
        .next_time   (next_time),
        .readd_error (readd_error),
        .last        (last)
    );

    // Leave the carry past the tail unused by design
    logic unused_carry;
    assign unused_carry = carry[SLOTS];

endmodule

`default_nettype wire

FILE: hw/rtl/tesq_checker.sv
// Port-level checker for the timed event slot queue and its bind to the top
// level. Depends on tesq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tesq_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    input  logic                               cmd_stall,
    input  logic                               rsp_valid,
    input  logic                               rsp_stall,
    input  logic [tesq_pkg::CmdW-1:0]          kind,
    input  logic [tesq_pkg::IdW-1:0]           fired_id,
    input  logic                               fired_valid,
    input  logic [tesq_pkg::TimeW-1:0]         next_time,
    input  logic                               readd_error,
    input  logic                               last
);
    import tesq_pkg::*;

    // Hold a stalled result transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(kind) && $stable(fired_id)
            && $stable(fired_valid) && $stable(next_time) && $stable(last))
        else $error("stalled result changed");

    // Stall the command side right after a transaction is taken
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second command taken while one is in work");

    // Only fire results carry an expired event or continue the command
    a_more_fire: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (!last || fired_valid) |-> kind == CMD_FIRE)
        else $error("event or continuation on a non-fire result");

    // A non-final result always names a real event
    a_mid_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> fired_valid)
        else $error("non-final fire result without event");

    // Flag re-add errors on insert results only
    a_err_insert: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && readd_error |-> kind == CMD_INSERT)
        else $error("re-add error on a non-insert result");

endmodule

bind timed_event_slot_queue_top tesq_checker u_tesq_checker (.*);

`default_nettype wire
